FILE: rtl/core/jlms_pkg.sv
// Shared constants, types and the sequencer program of the jump-list search unit.
// Depends on nothing; the top level and the checker refer to it by scoped names.
`default_nettype none

package jlms_pkg;

   // Table geometry and field widths
   localparam int TABLE_DEPTH = 1024;
   localparam int ADDR_W      = $clog2(TABLE_DEPTH);
   localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
   localparam int VALUE_W     = 31;
   localparam int STRIDE_W    = 11;
   localparam int AHEAD_W     = ((CNT_W > STRIDE_W) ? CNT_W : STRIDE_W) + 1;
   localparam int CMD_W       = 2;
   localparam int STATUS_W    = 2;

   localparam logic [STRIDE_W-1:0] STRIDE_RESET = STRIDE_W'(32);

   // Command codes
   localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd0;
   localparam logic [CMD_W-1:0] CMD_APPEND = 2'd1;
   localparam logic [CMD_W-1:0] CMD_SEARCH = 2'd2;

   // Status codes
   localparam logic [STATUS_W-1:0] ST_LOADED   = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL     = 2'd1;
   localparam logic [STATUS_W-1:0] ST_CLEARED  = 2'd2;
   localparam logic [STATUS_W-1:0] ST_ANSWERED = 2'd3;

   // Sequencer steps
   localparam int STEP_W = 3;
   localparam logic [STEP_W-1:0] STEP_FETCH  = 3'd0;
   localparam logic [STEP_W-1:0] STEP_CLEAR  = 3'd1;
   localparam logic [STEP_W-1:0] STEP_APPEND = 3'd2;
   localparam logic [STEP_W-1:0] STEP_INIT   = 3'd3;
   localparam logic [STEP_W-1:0] STEP_PROBE  = 3'd4;
   localparam logic [STEP_W-1:0] STEP_EVAL   = 3'd5;
   localparam logic [STEP_W-1:0] STEP_EMIT   = 3'd6;

   // Datapath operations
   localparam int OP_W = 3;
   localparam logic [OP_W-1:0] OP_LATCH  = 3'd0;
   localparam logic [OP_W-1:0] OP_CLEAR  = 3'd1;
   localparam logic [OP_W-1:0] OP_APPEND = 3'd2;
   localparam logic [OP_W-1:0] OP_INIT   = 3'd3;
   localparam logic [OP_W-1:0] OP_PROBE  = 3'd4;
   localparam logic [OP_W-1:0] OP_WALK   = 3'd5;
   localparam logic [OP_W-1:0] OP_EMIT   = 3'd6;
   localparam logic [OP_W-1:0] OP_NONE   = 3'd7;

   // Jump conditions
   localparam int COND_W = 3;
   localparam logic [COND_W-1:0] COND_NEVER    = 3'd0;
   localparam logic [COND_W-1:0] COND_PAST_END = 3'd1;
   localparam logic [COND_W-1:0] COND_HIT      = 3'd2;
   localparam logic [COND_W-1:0] COND_OUT_BUSY = 3'd3;

   typedef struct packed {
      logic              ready;     // offer req_tready in this step
      logic              dispatch;  // branch on the accepted command
      logic [OP_W-1:0]   op;
      logic [COND_W-1:0] cond;
      logic [STEP_W-1:0] jump_step; // taken when cond holds
      logic [STEP_W-1:0] next_step; // taken otherwise
   } ucode_type;

   // Program ROM: one control word per step
   function automatic ucode_type ucode_word(input logic [STEP_W-1:0] step);
      ucode_type w;
      w = '{ready: 1'b0, dispatch: 1'b0, op: OP_NONE, cond: COND_NEVER,
            jump_step: STEP_FETCH, next_step: STEP_FETCH};
      case (step)
         STEP_FETCH: begin
            w.ready    = 1'b1;
            w.dispatch = 1'b1;
            w.op       = OP_LATCH;
         end
         STEP_CLEAR: begin
            w.op        = OP_CLEAR;
            w.next_step = STEP_EMIT;
         end
         STEP_APPEND: begin
            w.op        = OP_APPEND;
            w.next_step = STEP_EMIT;
         end
         STEP_INIT: begin
            w.op        = OP_INIT;
            w.next_step = STEP_PROBE;
         end
         STEP_PROBE: begin
            w.op        = OP_PROBE;
            w.cond      = COND_PAST_END;
            w.jump_step = STEP_EMIT;
            w.next_step = STEP_EVAL;
         end
         STEP_EVAL: begin
            w.op        = OP_WALK;
            w.cond      = COND_HIT;
            w.jump_step = STEP_EMIT;
            w.next_step = STEP_PROBE;
         end
         STEP_EMIT: begin
            w.op        = OP_EMIT;
            w.cond      = COND_OUT_BUSY;
            w.jump_step = STEP_EMIT;
            w.next_step = STEP_FETCH;
         end
         default: begin
            w.next_step = STEP_FETCH;
         end
      endcase
      return w;
   endfunction

   // Dispatch table: first step of each command; the unused code returns to fetch
   function automatic logic [STEP_W-1:0] dispatch_step(input logic [CMD_W-1:0] cmd);
      logic [STEP_W-1:0] s;
      case (cmd)
         CMD_CLEAR:  s = STEP_CLEAR;
         CMD_APPEND: s = STEP_APPEND;
         CMD_SEARCH: s = STEP_INIT;
         default:    s = STEP_FETCH;
      endcase
      return s;
   endfunction

endpackage

`default_nettype wire

FILE: rtl/core/jlms_ram.sv
// Generic RAM: one write port, two read ports with registered read data.
// Stand-alone; no package needed.
`default_nettype none

module jlms_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr_a,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic      [WIDTH-1:0]         rd_data_a,
   output logic      [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_a <= mem[rd_addr_a];
         rd_data_b <= mem[rd_addr_b];
      end
   end

endmodule

`default_nettype wire

FILE: rtl/core/jump_list_membership_search_unit.sv
// Top level of the jump-list membership search unit: microcoded sequencer and datapath.
// Depends on jlms_pkg (constants, program ROM) and jlms_ram (value table).
`default_nettype none

// Channel   Dir   Ports                     Contents
// req       in    req_tvalid/tready/tdata   tdata: value[30:0]; tuser: command[1:0]
// rsp       out   rsp_tvalid/tready/tdata   tdata: found[0]; tuser: status[1:0]
// csr       in    csr_wr_en/csr_wr_data     jump_stride[10:0]
//
// Clear and append run the fetch, operate and emit steps; emit loads the result into
//   the output register, waiting while an earlier result is still held there.
// A search runs fetch and init, then a probe and an evaluate step for each position
//   visited, and goes to emit when the key turns up or when a last probe finds that the
//   walk has run past the end: each visit is one read of both RAM ports (current entry
//   and express target) and one evaluate step.
// Reset is synchronous: step counter, entry count, result valid and stride return
//   to their reset values; the table needs no clearing pass.
// One item is in work at a time; req_tready is high only in the fetch step, which
//   also runs while an earlier result waits in the output register.
// A held result stalls the sequencer only when a second result is ready to leave.

module jump_list_membership_search_unit (
   input  wire logic        clock,
   input  wire logic        reset,
   // request: tdata = value[30:0], zero pad [31]; tuser = command[1:0]
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [31:0] req_tdata,
   input  wire logic [1:0]  req_tuser,
   // response: tdata = found[0], zero pad [7:1]; tuser = status[1:0]
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic      [7:0]  rsp_tdata,
   output logic      [1:0]  rsp_tuser,
   // configuration: jump_stride
   input  wire logic        csr_wr_en,
   input  wire logic [10:0] csr_wr_data
);

   // Sequencer
   logic [jlms_pkg::STEP_W-1:0] step_ff, step_in;
   jlms_pkg::ucode_type         uw;
   logic                        req_accept;
   logic                        cond_true;

   // Datapath registers
   logic [jlms_pkg::STRIDE_W-1:0] stride_ff;
   logic [jlms_pkg::CNT_W-1:0]    count_ff, count_in;
   logic [jlms_pkg::CNT_W-1:0]    pos_ff, pos_in;
   logic [jlms_pkg::STRIDE_W-1:0] phase_ff, phase_in;
   logic [jlms_pkg::VALUE_W-1:0]  key_ff, key_in;
   logic [jlms_pkg::STATUS_W-1:0] status_ff, status_in;
   logic                          found_ff, found_in;

   // Output register
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [jlms_pkg::STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic                          rsp_found_ff, rsp_found_in;
   logic                          out_busy;
   logic                          emit_load;

   // Walk arithmetic
   logic [jlms_pkg::STRIDE_W-1:0] stride_eff;
   logic [jlms_pkg::AHEAD_W-1:0]  ahead;
   logic                          ahead_ok;
   logic [jlms_pkg::STRIDE_W-1:0] phase_inc;
   logic                          hit;
   logic                          jump_ok;

   // Table
   logic                          wr_en;
   logic                          rd_en;
   logic [jlms_pkg::VALUE_W-1:0]  here_data, ahead_data;

   assign uw         = jlms_pkg::ucode_word(step_ff);
   assign req_tready = uw.ready;
   assign req_accept = req_tvalid & req_tready;

   // A stride of zero walks one position at a time
   assign stride_eff = (stride_ff == '0) ? jlms_pkg::STRIDE_W'(1) : stride_ff;
   assign ahead      = jlms_pkg::AHEAD_W'(pos_ff) + jlms_pkg::AHEAD_W'(stride_eff);
   assign ahead_ok   = ahead < jlms_pkg::AHEAD_W'(count_ff);
   assign phase_inc  = phase_ff + jlms_pkg::STRIDE_W'(1);
   assign hit        = (here_data == key_ff);
   // Express link only from a stride position, and only onto a value not above the key
   assign jump_ok    = (phase_ff == '0) & ahead_ok & (ahead_data <= key_ff);

   assign out_busy   = rsp_valid_ff & ~rsp_tready;

   // Jump condition select
   always_comb begin
      case (uw.cond)
         jlms_pkg::COND_NEVER:    cond_true = 1'b0;
         jlms_pkg::COND_PAST_END: cond_true = (pos_ff >= count_ff);
         jlms_pkg::COND_HIT:      cond_true = hit;
         jlms_pkg::COND_OUT_BUSY: cond_true = out_busy;
         default:                 cond_true = 1'b0;
      endcase
   end

   // Next step: dispatch on the accepted command, else branch or fall through
   always_comb begin
      if (uw.dispatch) begin
         step_in = req_accept ? jlms_pkg::dispatch_step(req_tuser) : step_ff;
      end else begin
         step_in = cond_true ? uw.jump_step : uw.next_step;
      end
   end

   // Datapath control
   always_comb begin
      count_in  = count_ff;
      pos_in    = pos_ff;
      phase_in  = phase_ff;
      key_in    = key_ff;
      status_in = status_ff;
      found_in  = found_ff;
      wr_en     = 1'b0;
      rd_en     = 1'b0;
      emit_load = 1'b0;
      case (uw.op)
         jlms_pkg::OP_LATCH: begin
            if (req_accept) begin
               key_in = req_tdata[jlms_pkg::VALUE_W-1:0];
            end
         end
         jlms_pkg::OP_CLEAR: begin
            // Drop the count; stale entries stay but their read data is never used
            count_in  = '0;
            status_in = jlms_pkg::ST_CLEARED;
            found_in  = 1'b0;
         end
         jlms_pkg::OP_APPEND: begin
            found_in = 1'b0;
            if (count_ff < jlms_pkg::CNT_W'(jlms_pkg::TABLE_DEPTH)) begin
               wr_en     = 1'b1;
               count_in  = count_ff + jlms_pkg::CNT_W'(1);
               status_in = jlms_pkg::ST_LOADED;
            end else begin
               status_in = jlms_pkg::ST_FULL;
            end
         end
         jlms_pkg::OP_INIT: begin
            pos_in    = '0;
            phase_in  = '0;
            status_in = jlms_pkg::ST_ANSWERED;
            found_in  = 1'b0;
         end
         jlms_pkg::OP_PROBE: begin
            rd_en = 1'b1;
         end
         jlms_pkg::OP_WALK: begin
            if (hit) begin
               found_in = 1'b1;
            end else if (jump_ok) begin
               // Target is a stride multiple too, so phase stays zero
               pos_in = ahead[jlms_pkg::CNT_W-1:0];
            end else begin
               pos_in   = pos_ff + jlms_pkg::CNT_W'(1);
               phase_in = (phase_inc == stride_eff) ? '0 : phase_inc;
            end
         end
         jlms_pkg::OP_EMIT: begin
            emit_load = ~out_busy;
         end
         default: begin
         end
      endcase
   end

   // Output register: load on emit, drop on handshake
   always_comb begin
      rsp_valid_in  = emit_load | out_busy;
      rsp_status_in = emit_load ? status_ff : rsp_status_ff;
      rsp_found_in  = emit_load ? found_ff  : rsp_found_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff      <= jlms_pkg::STEP_FETCH;
         count_ff     <= '0;
         stride_ff    <= jlms_pkg::STRIDE_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         step_ff      <= step_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            stride_ff <= csr_wr_data;
         end
      end
   end

   // Payload registers carry no reset
   always_ff @(posedge clock) begin
      pos_ff        <= pos_in;
      phase_ff      <= phase_in;
      key_ff        <= key_in;
      status_ff     <= status_in;
      found_ff      <= found_in;
      rsp_status_ff <= rsp_status_in;
      rsp_found_ff  <= rsp_found_in;
   end

   jlms_ram #(
      .WIDTH (jlms_pkg::VALUE_W),
      .DEPTH (jlms_pkg::TABLE_DEPTH)
   ) u_table (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (count_ff[jlms_pkg::ADDR_W-1:0]),
      .wr_data   (key_ff),
      .rd_en     (rd_en),
      .rd_addr_a (pos_ff[jlms_pkg::ADDR_W-1:0]),
      .rd_addr_b (ahead[jlms_pkg::ADDR_W-1:0]),
      .rd_data_a (here_data),
      .rd_data_b (ahead_data)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'b0, rsp_found_ff};
   assign rsp_tuser  = rsp_status_ff;

endmodule

`default_nettype wire

FILE: rtl/core/jlms_checker.sv
// Port-level checks for the jump-list search unit, bound to the top level.
// Depends on jlms_pkg for status codes.
`default_nettype none

module jlms_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [7:0]  rsp_tdata,
   input wire logic [1:0]  rsp_tuser
);

   // Hold a result until it is taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result dropped before handshake");

   // Only a query answer may report found
   a_found_query: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[0] |-> rsp_tuser == jlms_pkg::ST_ANSWERED)
      else $error("found set on a non-query result");

   // Pad bits of the result stay zero
   a_pad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[7:1] == 7'b0)
      else $error("result pad bits set");

   // No result is offered right after reset
   a_reset_idle: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("result valid after reset");

endmodule

bind jump_list_membership_search_unit jlms_checker u_jlms_checker (.*);

`default_nettype wire
